// ----- hw/rtl/fbba_pkg.sv -----
// shared types, constants and helper functions of the flash block allocator
`default_nettype none

package fbba_pkg;

  // default number of 32-bit words in each bitmap
  localparam int MAP_WORDS_DEF = 32;

  // fixed field and position widths
  localparam int POS_W    = 11;  // block position and next-fit pointer
  localparam int BIT_W    = 5;   // bit within a map word
  localparam int WORD_W   = 6;   // word index of a position
  localparam int WORD_X_W = 7;   // word index of a range limit
  localparam int LIM_W    = 12;  // scan range limits, up to 2048
  localparam int IDX_W    = 16;
  localparam int BLOCK_W  = 10;
  localparam int CFG_W    = 11;
  localparam int ENTRY_W  = 64;  // erase word over free word

  localparam logic [IDX_W-1:0] NULL_MARK = 16'hFFFF;

  // request kinds
  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_MARK    = 2'd1,
    K_UNDO    = 2'd2,
    K_RECLAIM = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_ERASES_DONE = 1'b1
  } cfg_index_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MREAD,
    S_WRITE,
    S_DONE
  } state_t;

  // map memory access from the controller
  typedef struct packed {
    logic               rd_en;
    logic [WORD_W-1:0]  rd_addr;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

  // one result item
  typedef struct packed {
    status_t            status;
    logic [BLOCK_W-1:0] block;
    logic               erase;
  } result_t;

  // index of the lowest set bit, five halving steps
  function automatic logic [BIT_W-1:0] lowest_set(input logic [31:0] v);
    logic [31:0]      t;
    logic [BIT_W-1:0] idx;
    t   = v;
    idx = '0;
    if (t[15:0] == 16'h0) begin
      idx[4] = 1'b1;
      t      = t >> 16;
    end
    if (t[7:0] == 8'h0) begin
      idx[3] = 1'b1;
      t      = t >> 8;
    end
    if (t[3:0] == 4'h0) begin
      idx[2] = 1'b1;
      t      = t >> 4;
    end
    if (t[1:0] == 2'h0) begin
      idx[1] = 1'b1;
      t      = t >> 2;
    end
    if (t[0] == 1'b0) begin
      idx[0] = 1'b1;
    end
    return idx;
  endfunction

  // bits of a word whose positions lie in [lo, hi)
  function automatic logic [31:0] range_mask(input logic [WORD_W-1:0] word,
                                             input logic [LIM_W-1:0]  lo,
                                             input logic [LIM_W-1:0]  hi);
    logic [WORD_X_W-1:0] wx;
    logic [WORD_X_W-1:0] lo_w;
    logic [WORD_X_W-1:0] hi_w;
    logic [31:0]         ge;
    logic [31:0]         lt;
    wx   = {1'b0, word};
    lo_w = lo[LIM_W-1:BIT_W];
    hi_w = hi[LIM_W-1:BIT_W];
    if (lo_w < wx) begin
      ge = '1;
    end else if (lo_w == wx) begin
      ge = 32'hFFFF_FFFF << lo[BIT_W-1:0];
    end else begin
      ge = '0;
    end
    if (hi_w > wx) begin
      lt = '1;
    end else if (hi_w == wx) begin
      lt = ~(32'hFFFF_FFFF << hi[BIT_W-1:0]);
    end else begin
      lt = '0;
    end
    return ge & lt;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fbba_map_mem.sv -----
// bitmap memory: free and erase words side by side, registered read
`default_nettype none

module fbba_map_mem #(
  parameter int MAP_WORDS = fbba_pkg::MAP_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire fbba_pkg::mem_req_t             req,
  output logic [fbba_pkg::ENTRY_W-1:0]        rdata
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [fbba_pkg::ENTRY_W-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]         valid;
  logic [fbba_pkg::ENTRY_W-1:0] q;
  logic                         q_valid;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // per-word written flags, unwritten words read as all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  // read port with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
        q       <= req.wr_data;
        q_valid <= 1'b1;
      end else begin
        q       <= mem[req.rd_addr[AW-1:0]];
        q_valid <= valid[req.rd_addr[AW-1:0]];
      end
    end
  end

  assign rdata = q_valid ? q : '1;

endmodule

`default_nettype wire

// ----- hw/rtl/fbba_ctrl.sv -----
// request sequencer: next-fit and reclaim scans, mark updates, read-modify-write
`default_nettype none

module fbba_ctrl #(
  parameter int MAP_WORDS = fbba_pkg::MAP_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [1:0]                     kind,
  input  wire logic [fbba_pkg::IDX_W-1:0]     block_index,
  output logic                                in_stall,
  input  wire logic [fbba_pkg::POS_W-1:0]     block_count,
  input  wire logic                           erases_done,
  output fbba_pkg::mem_req_t                  mem_req,
  input  wire logic [fbba_pkg::ENTRY_W-1:0]   mem_rdata,
  input  wire logic                           out_ready,
  output logic                                push,
  output fbba_pkg::result_t                   push_data
);

  localparam int POS_W    = fbba_pkg::POS_W;
  localparam int BIT_W    = fbba_pkg::BIT_W;
  localparam int WORD_W   = fbba_pkg::WORD_W;
  localparam int WORD_X_W = fbba_pkg::WORD_X_W;
  localparam int LIM_W    = fbba_pkg::LIM_W;
  localparam int IDX_W    = fbba_pkg::IDX_W;
  localparam int ENTRY_W  = fbba_pkg::ENTRY_W;
  localparam int BLOCK_W  = fbba_pkg::BLOCK_W;

  localparam logic [LIM_W-1:0]    MAP_BITS   = LIM_W'(MAP_WORDS * 32);
  localparam logic [IDX_W-1:0]    MAP_BITS_X = IDX_W'(MAP_WORDS * 32);
  localparam logic [WORD_X_W-1:0] LAST_WORD  = WORD_X_W'(MAP_WORDS - 1);

  fbba_pkg::state_t  state, state_next;
  fbba_pkg::kind_t   kind_q, kind_q_next;
  fbba_pkg::result_t res, res_next;

  logic [POS_W-1:0]   ptr, ptr_next;
  logic [POS_W-1:0]   start_s, start_s_next;
  logic [LIM_W-1:0]   lo, lo_next;
  logic [LIM_W-1:0]   hi, hi_next;
  logic [WORD_W-1:0]  last_w, last_w_next;
  logic [WORD_W-1:0]  issue_w, issue_w_next;
  logic               issue_act, issue_act_next;
  logic               pend, pend_next;
  logic [WORD_W-1:0]  pend_w, pend_w_next;
  logic               phase_b, phase_b_next;
  logic               phase_empty, phase_empty_next;
  logic [WORD_W-1:0]  found_w, found_w_next;
  logic [BIT_W-1:0]   found_bit, found_bit_next;
  logic [ENTRY_W-1:0] hold, hold_next;

  logic               accept;
  logic               idx_null;
  logic               idx_range;
  logic               mark_hit;
  logic [POS_W-1:0]   s_acc;
  logic [LIM_W-1:0]   setup_lo;
  logic [LIM_W-1:0]   setup_hi;
  logic [LIM_W-1:0]   hi_m1;
  logic [WORD_X_W-1:0] setup_first;
  logic [WORD_X_W-1:0] setup_last;
  logic               setup_empty;
  logic [31:0]        sel_bits;
  logic [31:0]        masked;
  logic               found;
  logic               phase_end;
  logic               go_b;
  logic               scan_issue;
  logic [31:0]        bit_mask;
  logic [POS_W-1:0]   pos;

  // request decode
  assign accept    = in_valid && (state == fbba_pkg::S_IDLE);
  assign idx_null  = (block_index == fbba_pkg::NULL_MARK);
  assign idx_range = !idx_null && (block_index >= MAP_BITS_X);
  assign mark_hit  = ((kind == fbba_pkg::K_MARK) || (kind == fbba_pkg::K_UNDO)) &&
                     !idx_null && !idx_range;
  assign s_acc     = (ptr >= block_count) ? '0 : ptr;

  // scan range of the phase about to start
  always_comb begin
    if (state == fbba_pkg::S_SCAN) begin
      setup_lo = '0;
      setup_hi = {1'b0, start_s};
    end else if (kind == fbba_pkg::K_RECLAIM) begin
      setup_lo = '0;
      setup_hi = MAP_BITS;
    end else begin
      setup_lo = {1'b0, s_acc};
      setup_hi = {1'b0, block_count};
    end
    hi_m1       = setup_hi - LIM_W'(1);
    setup_first = setup_lo[LIM_W-1:BIT_W];
    setup_last  = (hi_m1[LIM_W-1:BIT_W] > LAST_WORD) ? LAST_WORD : hi_m1[LIM_W-1:BIT_W];
    setup_empty = (setup_hi <= setup_lo) || (setup_first > LAST_WORD);
  end

  // word evaluation of the scan
  assign sel_bits   = (kind_q == fbba_pkg::K_ALLOC) ? mem_rdata[31:0] : ~mem_rdata[63:32];
  assign masked     = sel_bits & fbba_pkg::range_mask(pend_w, lo, hi);
  assign found      = pend && !phase_empty && (masked != 32'h0);
  assign phase_end  = phase_empty || (pend && !found && (pend_w == last_w));
  assign go_b       = (kind_q == fbba_pkg::K_ALLOC) && !phase_b && (start_s != '0);
  assign scan_issue = (state == fbba_pkg::S_SCAN) && !found && !phase_end && issue_act;
  assign bit_mask   = 32'h1 << found_bit;
  assign pos        = {found_w, found_bit};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fbba_pkg::S_IDLE: begin
        if (accept) begin
          if ((kind == fbba_pkg::K_ALLOC) || (kind == fbba_pkg::K_RECLAIM)) begin
            state_next = fbba_pkg::S_SCAN;
          end else if (mark_hit) begin
            state_next = fbba_pkg::S_MREAD;
          end else begin
            state_next = fbba_pkg::S_DONE;
          end
        end
      end
      fbba_pkg::S_SCAN: begin
        if (found) begin
          state_next = fbba_pkg::S_WRITE;
        end else if (phase_end && !go_b) begin
          state_next = fbba_pkg::S_DONE;
        end
      end
      fbba_pkg::S_MREAD: begin
        state_next = fbba_pkg::S_WRITE;
      end
      fbba_pkg::S_WRITE: begin
        state_next = fbba_pkg::S_DONE;
      end
      fbba_pkg::S_DONE: begin
        if (out_ready) begin
          state_next = fbba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fbba_pkg::S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    kind_q_next      = kind_q;
    res_next         = res;
    ptr_next         = ptr;
    start_s_next     = start_s;
    lo_next          = lo;
    hi_next          = hi;
    last_w_next      = last_w;
    issue_w_next     = issue_w;
    issue_act_next   = issue_act;
    pend_next        = pend;
    pend_w_next      = pend_w;
    phase_b_next     = phase_b;
    phase_empty_next = phase_empty;
    found_w_next     = found_w;
    found_bit_next   = found_bit;
    hold_next        = hold;
    case (state)
      fbba_pkg::S_IDLE: begin
        if (accept) begin
          kind_q_next      = fbba_pkg::kind_t'(kind);
          res_next         = '{status: fbba_pkg::ST_OK, block: '0, erase: 1'b0};
          phase_b_next     = 1'b0;
          pend_next        = 1'b0;
          start_s_next     = s_acc;
          lo_next          = setup_lo;
          hi_next          = setup_hi;
          last_w_next      = setup_last[WORD_W-1:0];
          issue_w_next     = setup_first[WORD_W-1:0];
          issue_act_next   = !setup_empty;
          phase_empty_next = setup_empty;
          found_w_next     = block_index[POS_W-1:BIT_W];
          found_bit_next   = block_index[BIT_W-1:0];
          if (idx_range && (kind != fbba_pkg::K_ALLOC) && (kind != fbba_pkg::K_RECLAIM)) begin
            res_next.status = fbba_pkg::ST_RANGE;
          end
        end
      end
      fbba_pkg::S_SCAN: begin
        if (found) begin
          found_w_next   = pend_w;
          found_bit_next = fbba_pkg::lowest_set(masked);
          hold_next      = mem_rdata;
          pend_next      = 1'b0;
        end else if (phase_end) begin
          pend_next = 1'b0;
          if (go_b) begin
            // wrapped part of the next-fit scan, below the start
            phase_b_next     = 1'b1;
            lo_next          = setup_lo;
            hi_next          = setup_hi;
            last_w_next      = setup_last[WORD_W-1:0];
            issue_w_next     = setup_first[WORD_W-1:0];
            issue_act_next   = !setup_empty;
            phase_empty_next = setup_empty;
          end else begin
            res_next.status = fbba_pkg::ST_NONE;
            if ((kind_q == fbba_pkg::K_ALLOC) && (block_count != '0)) begin
              ptr_next = (start_s == '0) ? block_count : start_s;
            end
          end
        end else if (scan_issue) begin
          issue_w_next   = issue_w + WORD_W'(1);
          issue_act_next = (issue_w != last_w);
          pend_next      = 1'b1;
          pend_w_next    = issue_w;
        end else begin
          pend_next = 1'b0;
        end
      end
      fbba_pkg::S_MREAD: begin
        hold_next = mem_rdata;
      end
      fbba_pkg::S_WRITE: begin
        if (kind_q == fbba_pkg::K_ALLOC) begin
          res_next.block = pos[BLOCK_W-1:0];
          ptr_next       = pos + POS_W'(1);
        end else if (kind_q == fbba_pkg::K_RECLAIM) begin
          res_next.block = pos[BLOCK_W-1:0];
          res_next.erase = !erases_done;
        end
      end
      default: begin
      end
    endcase
  end

  // memory access, handshake and result push
  always_comb begin
    mem_req.rd_en   = scan_issue || (accept && mark_hit);
    mem_req.rd_addr = (state == fbba_pkg::S_SCAN) ? issue_w : block_index[POS_W-1:BIT_W];
    mem_req.wr_en   = (state == fbba_pkg::S_WRITE);
    mem_req.wr_addr = found_w;
    case (kind_q)
      fbba_pkg::K_ALLOC:   mem_req.wr_data = {hold[63:32], hold[31:0] & ~bit_mask};
      fbba_pkg::K_MARK:    mem_req.wr_data = {hold[63:32] & ~bit_mask, hold[31:0]};
      fbba_pkg::K_UNDO:    mem_req.wr_data = {hold[63:32] | bit_mask, hold[31:0]};
      fbba_pkg::K_RECLAIM: mem_req.wr_data = {hold[63:32] | bit_mask, hold[31:0] | bit_mask};
      default:             mem_req.wr_data = hold;
    endcase
    in_stall  = (state != fbba_pkg::S_IDLE);
    push      = (state == fbba_pkg::S_DONE) && out_ready;
    push_data = res;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbba_pkg::S_IDLE;
      ptr       <= '0;
      issue_act <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      issue_act <= issue_act_next;
      pend      <= pend_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_q      <= kind_q_next;
    res         <= res_next;
    start_s     <= start_s_next;
    lo          <= lo_next;
    hi          <= hi_next;
    last_w      <= last_w_next;
    issue_w     <= issue_w_next;
    pend_w      <= pend_w_next;
    phase_b     <= phase_b_next;
    phase_empty <= phase_empty_next;
    found_w     <= found_w_next;
    found_bit   <= found_bit_next;
    hold        <= hold_next;
  end

  // an allocated block was free in the word that gets written back
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (state == fbba_pkg::S_WRITE) && (kind_q == fbba_pkg::K_ALLOC) |-> hold[{1'b0, found_bit}])
    else $error("allocate claims a block that is not free");

  // a reclaimed block was marked
  a_reclaim_marked: assert property (@(posedge clk) disable iff (rst)
    (state == fbba_pkg::S_WRITE) && (kind_q == fbba_pkg::K_RECLAIM) |->
      !hold[{1'b1, found_bit}])
    else $error("reclaim frees a block that is not marked");

  // allocation stays inside the pool
  a_alloc_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == fbba_pkg::S_WRITE) && (kind_q == fbba_pkg::K_ALLOC) |-> (pos < block_count))
    else $error("allocated block beyond block count");

  // map reads, scan and mark, stay inside the map
  a_read_in_map: assert property (@(posedge clk) disable iff (rst)
    mem_req.rd_en |-> ({1'b0, mem_req.rd_addr} <= LAST_WORD))
    else $error("map read beyond last word");

endmodule

`default_nettype wire

// ----- hw/rtl/fbba_out_reg.sv -----
// result output register between the sequencer and the result channel
`default_nettype none

module fbba_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire fbba_pkg::result_t             push_data,
  output logic                               ready,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic [fbba_pkg::BLOCK_W-1:0]       result_block,
  output logic                               erase_needed
);

  logic              full;
  fbba_pkg::result_t data;

  // slot frees up when the held result is taken
  assign ready = !full || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

  assign out_valid    = full;
  assign status       = data.status;
  assign result_block = data.block;
  assign erase_needed = data.erase;

endmodule

`default_nettype wire

// ----- hw/rtl/flash_block_bitmap_allocator.sv -----
// top level of the flash block allocator: config registers, sequencer, map memory, output
//
//  port group   direction   handshake            payload
//  request      in          in_valid / in_stall  kind, block_index
//  result       out         out_valid / out_stall status, result_block, erase_needed
//  config       in          cfg_write            cfg_index, cfg_data
//
// allocate and reclaim scan the map through the single read port of the map memory
// (one word a cycle). mark and undo read, modify and write back the addressed word;
// null or out-of-range marks and undos go straight to the result.
// reset is synchronous; no clearing pass, unwritten map words read as all ones.
// a stalled result is held in the output register while the next request runs.
`default_nettype none

module flash_block_bitmap_allocator #(
  parameter int MAP_WORDS = fbba_pkg::MAP_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [fbba_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    kind,
  input  wire logic [fbba_pkg::IDX_W-1:0]    block_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic [fbba_pkg::BLOCK_W-1:0]       result_block,
  output logic                               erase_needed
);

  logic [fbba_pkg::POS_W-1:0]   block_count;
  logic                         erases_done;
  fbba_pkg::mem_req_t           mem_req;
  logic [fbba_pkg::ENTRY_W-1:0] mem_rdata;
  logic                         out_ready;
  logic                         push;
  fbba_pkg::result_t            push_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      erases_done <= 1'b0;
    end else if (cfg_write) begin
      case (fbba_pkg::cfg_index_t'(cfg_index))
        fbba_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data[fbba_pkg::POS_W-1:0];
        fbba_pkg::CFG_ERASES_DONE: erases_done <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // request sequencer
  fbba_ctrl #(
    .MAP_WORDS (MAP_WORDS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .kind        (kind),
    .block_index (block_index),
    .in_stall    (in_stall),
    .block_count (block_count),
    .erases_done (erases_done),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .out_ready   (out_ready),
    .push        (push),
    .push_data   (push_data)
  );

  // free and erase bitmaps
  fbba_map_mem #(
    .MAP_WORDS (MAP_WORDS)
  ) u_map_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // result register
  fbba_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .ready        (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_block (result_block),
    .erase_needed (erase_needed)
  );

endmodule

`default_nettype wire
